// ===== design/indexed_framebuffer_palette_engine_unit_assert.svh =====
// Assertion macros shared by the frame buffer engine modules.
`ifndef INDEXED_FRAMEBUFFER_PALETTE_ENGINE_UNIT_ASSERT_SVH
`define INDEXED_FRAMEBUFFER_PALETTE_ENGINE_UNIT_ASSERT_SVH

// Checked property with the reset as disable condition.
`define IFPE_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked property that also holds during reset.
`define IFPE_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ifpe_pkg.sv =====
// Shared constants, codes and command type of the frame buffer engine.
package ifpe_pkg;

    localparam int WIDTH      = 240;
    localparam int HEIGHT     = 240;
    localparam int STORE_SIZE = WIDTH * HEIGHT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int MAX_ADDR   = 255 * WIDTH + 255 + 254 * WIDTH;
    localparam int EXT_W      = $clog2(MAX_ADDR + 1);
    localparam int PAL_DEPTH  = 256;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_PUT    = 3'd0,
        OP_FILL_H = 3'd1,
        OP_FILL_V = 3'd2,
        OP_READ   = 3'd3,
        OP_PAL_WR = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        CMD_FILL_H,
        CMD_FILL_V,
        CMD_READ,
        CMD_PAL_WR
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [EXT_W-1:0]   addr;
        logic [7:0]         count;
        logic [7:0]         color_index;
        logic [15:0]        palette_color;
    } cmd_t;

endpackage

// ===== design/ifpe_front.sv =====
// Front end: accepts input beats, decodes them and forms queue commands.
module ifpe_front (
    input  logic [2:0]      s_operation,
    input  logic [7:0]      s_x_pos,
    input  logic [7:0]      s_y_pos,
    input  logic [7:0]      s_run_length,
    input  logic [7:0]      s_color_index,
    input  logic [15:0]     s_palette_color,
    input  logic            accept,
    output logic            push,
    output ifpe_pkg::cmd_t  push_cmd
);
    import ifpe_pkg::*;

    logic [EXT_W-1:0] base;

    assign base = EXT_W'(s_y_pos) * EXT_W'(WIDTH) + EXT_W'(s_x_pos);

    always_comb begin
        push_cmd.kind          = CMD_FILL_H;
        push_cmd.addr          = base;
        push_cmd.count         = s_run_length;
        push_cmd.color_index   = s_color_index;
        push_cmd.palette_color = s_palette_color;
        push                   = 1'b0;
        unique case (s_operation)
            OP_PUT: begin
                push_cmd.count = 8'd1;
                push           = accept;
            end
            OP_FILL_H: begin
                push = accept && (s_run_length != 8'd0);
            end
            OP_FILL_V: begin
                push_cmd.kind = CMD_FILL_V;
                push          = accept && (s_run_length != 8'd0);
            end
            OP_READ: begin
                push_cmd.kind = CMD_READ;
                push          = accept;
            end
            OP_PAL_WR: begin
                push_cmd.kind = CMD_PAL_WR;
                push          = accept;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

endmodule

// ===== design/ifpe_fifo.sv =====
// Short command queue between the front end and the execution back end.
`include "indexed_framebuffer_palette_engine_unit_assert.svh"
module ifpe_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  ifpe_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            pop_valid,
    output ifpe_pkg::cmd_t  pop_cmd
);
    import ifpe_pkg::*;

    cmd_t             slots_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(FIFO_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = slots_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `IFPE_ASSERT(a_fifo_bound, aclk, aresetn, count_reg <= CNT_W'(FIFO_DEPTH), "queue overfilled")
    `IFPE_ASSERT(a_fifo_grow, aclk, aresetn, (push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1), "queue count did not grow")
    `IFPE_ASSERT(a_fifo_shrink, aclk, aresetn, (!push && do_pop) |=> (count_reg == $past(count_reg) - 1'b1), "queue count did not shrink")

endmodule

// ===== design/ifpe_back.sv =====
// Back end: runs queued commands against the frame store and palette.
`include "indexed_framebuffer_palette_engine_unit_assert.svh"
module ifpe_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cmd_valid,
    input  ifpe_pkg::cmd_t  cmd,
    output logic            cmd_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [15:0]     m_pixel_color
);
    import ifpe_pkg::*;

    logic [7:0]  frame_mem [STORE_SIZE];
    logic [15:0] pal_mem   [PAL_DEPTH];

    logic             cur_valid_reg, cur_valid_next;
    cmd_kind_t        cur_kind_reg, cur_kind_next;
    logic [EXT_W-1:0] addr_reg, addr_next;
    logic [7:0]       remain_reg, remain_next;
    logic [7:0]       idx_reg, idx_next;
    logic [15:0]      rgb_reg, rgb_next;

    logic             f_valid_reg, f_valid_next;
    logic             f_oob_reg, f_oob_next;
    logic [7:0]       frame_data_reg;
    logic             p_valid_reg, p_valid_next;
    logic             p_oob_reg, p_oob_next;
    logic [15:0]      pal_data_reg;
    logic             m_valid_reg, m_valid_next;
    logic [15:0]      m_pixel_reg, m_pixel_next;

    logic out_free, pal_can, frame_can;
    logic is_fill, in_store, cur_done, take;
    logic frame_we, frame_re, pal_re, pal_we;

    assign out_free  = !m_valid_reg || m_ready;
    assign pal_can   = !p_valid_reg || out_free;
    assign frame_can = !f_valid_reg || pal_can;
    assign is_fill   = (cur_kind_reg == CMD_FILL_H) || (cur_kind_reg == CMD_FILL_V);
    assign in_store  = (addr_reg < EXT_W'(STORE_SIZE));

    always_comb begin
        unique case (cur_kind_reg)
            CMD_FILL_H, CMD_FILL_V: cur_done = (remain_reg == 8'd1);
            CMD_READ, CMD_PAL_WR:   cur_done = frame_can;
            default:                cur_done = 1'b1;
        endcase
    end

    assign take     = !cur_valid_reg || cur_done;
    assign cmd_pop  = take && cmd_valid;
    assign frame_we = cur_valid_reg && is_fill && in_store;
    assign frame_re = cur_valid_reg && (cur_kind_reg == CMD_READ) && frame_can;
    assign pal_we   = cur_valid_reg && (cur_kind_reg == CMD_PAL_WR) && frame_can;
    assign pal_re   = f_valid_reg && pal_can;

    always_comb begin
        cur_valid_next = cur_valid_reg;
        cur_kind_next  = cur_kind_reg;
        addr_next      = addr_reg;
        remain_next    = remain_reg;
        idx_next       = idx_reg;
        rgb_next       = rgb_reg;
        if (take) begin
            cur_valid_next = cmd_valid;
            cur_kind_next  = cmd.kind;
            addr_next      = cmd.addr;
            remain_next    = cmd.count;
            idx_next       = cmd.color_index;
            rgb_next       = cmd.palette_color;
        end else if (is_fill) begin
            addr_next   = (cur_kind_reg == CMD_FILL_V) ? addr_reg + EXT_W'(WIDTH)
                                                        : addr_reg + 1'b1;
            remain_next = remain_reg - 8'd1;
        end

        f_valid_next = f_valid_reg;
        f_oob_next   = f_oob_reg;
        if (frame_can) begin
            f_valid_next = frame_re;
            f_oob_next   = !in_store;
        end

        p_valid_next = p_valid_reg;
        p_oob_next   = p_oob_reg;
        if (pal_can) begin
            p_valid_next = f_valid_reg;
            p_oob_next   = f_oob_reg;
        end

        m_valid_next = m_valid_reg;
        m_pixel_next = m_pixel_reg;
        if (out_free) begin
            m_valid_next = p_valid_reg;
            m_pixel_next = p_oob_reg ? 16'd0 : pal_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            f_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            f_valid_reg   <= f_valid_next;
            p_valid_reg   <= p_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_kind_reg <= cur_kind_next;
        addr_reg     <= addr_next;
        remain_reg   <= remain_next;
        idx_reg      <= idx_next;
        rgb_reg      <= rgb_next;
        f_oob_reg    <= f_oob_next;
        p_oob_reg    <= p_oob_next;
        m_pixel_reg  <= m_pixel_next;
    end

    always_ff @(posedge aclk) begin
        if (frame_we) begin
            frame_mem[addr_reg[ADDR_W-1:0]] <= idx_reg;
        end
        if (frame_re && in_store) begin
            frame_data_reg <= frame_mem[addr_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (pal_we) begin
            pal_mem[idx_reg] <= rgb_reg;
        end
        if (pal_re) begin
            pal_data_reg <= pal_mem[frame_data_reg];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pixel_color = m_pixel_reg;

    `IFPE_ASSERT(a_fill_count, aclk, aresetn, (cur_valid_reg && is_fill) |-> (remain_reg != 8'd0), "fill running with zero count")
    `IFPE_ASSERT(a_frame_hold, aclk, aresetn, (f_valid_reg && !pal_can) |=> (f_valid_reg && $stable(frame_data_reg)), "frame stage lost its data")
    `IFPE_ASSERT(a_pal_hold, aclk, aresetn, (p_valid_reg && !out_free) |=> (p_valid_reg && $stable(pal_data_reg)), "palette stage lost its data")

endmodule

// ===== design/indexed_framebuffer_palette_engine_unit.sv =====
// Top level of the indexed frame buffer engine with palette lookup.
// An 8-bit indexed frame store of 240 by 240 pixels and a 256-entry RGB565 palette sit
// behind a valid/ready input channel; each input beat is one operation, and only a scanout
// read returns a beat, the palette color of one stored pixel or zero outside the store. A
// decoder takes one beat per cycle, while the queue is not full, into a four-entry command
// queue, and the execution end works through the queue in order: put pixel, scanout read
// and palette write are single steps, while a fill writes its run_length pixels one by one
// through the single write port of the frame store. A read passes through the frame
// store, palette and output registers. Neither memory is cleared by reset, so no pixel or
// palette entry should be read before it has been written.
module indexed_framebuffer_palette_engine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_operation,
    input  logic [7:0]  s_x_pos,
    input  logic [7:0]  s_y_pos,
    input  logic [7:0]  s_run_length,
    input  logic [7:0]  s_color_index,
    input  logic [15:0] s_palette_color,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_pixel_color
);
    import ifpe_pkg::*;

    logic full, push, pop, pop_valid;
    cmd_t push_cmd, pop_cmd;

    assign s_ready = !full;

    ifpe_front u_front (
        .s_operation     (s_operation),
        .s_x_pos         (s_x_pos),
        .s_y_pos         (s_y_pos),
        .s_run_length    (s_run_length),
        .s_color_index   (s_color_index),
        .s_palette_color (s_palette_color),
        .accept          (s_valid && s_ready),
        .push            (push),
        .push_cmd        (push_cmd)
    );

    ifpe_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd)
    );

    ifpe_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (pop_valid),
        .cmd           (pop_cmd),
        .cmd_pop       (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_color (m_pixel_color)
    );

endmodule
